/* sv/sccb_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the sccb register master
// no dependencies; compiled first

package sccb_pkg;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register map: index is paddr / 4
    typedef enum logic [0:0] {
        REG_DEVICE_ADDRESS = 1'b0
    } t_reg_idx;

    localparam logic [6:0] DEV_ADDR_RESET = 7'd92;

    // transaction kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic        start_req;
        logic        op;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic        sda_in;
    } t_in_item;

    typedef struct packed {
        logic        scl;
        logic        sda_oe;
        logic        sda_out;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_data;
        logic        nack;
    } t_out_item;

    // bus sequencer phases, one-hot
    typedef enum logic [17:0] {
        PH_IDLE = 18'b000000000000000001,
        PH_ST1  = 18'b000000000000000010,
        PH_ST2  = 18'b000000000000000100,
        PH_TXA  = 18'b000000000000001000,
        PH_TXB  = 18'b000000000000010000,
        PH_TXC  = 18'b000000000000100000,
        PH_AKA  = 18'b000000000001000000,
        PH_AKB  = 18'b000000000010000000,
        PH_AKC  = 18'b000000000100000000,
        PH_RXA  = 18'b000000001000000000,
        PH_RXB  = 18'b000000010000000000,
        PH_RXC  = 18'b000000100000000000,
        PH_MAA  = 18'b000001000000000000,
        PH_MAB  = 18'b000010000000000000,
        PH_MAC  = 18'b000100000000000000,
        PH_SP1  = 18'b001000000000000000,
        PH_SP2  = 18'b010000000000000000,
        PH_SP3  = 18'b100000000000000000
    } t_phase;

endpackage

/* sv/sccb_if.sv */
`timescale 1ns / 1ps
// valid/ready channel interfaces for tick items and result items
// depends on sccb_pkg

interface sccb_in_if;
    import sccb_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sccb_out_if;
    import sccb_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* sv/sccb_apb_regs.sv */
`timescale 1ns / 1ps
// apb configuration register file: holds the device bus address
// depends on sccb_pkg

module sccb_apb_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [sccb_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [sccb_pkg::PDATA_W-1:0]   i_pwdata,
    output logic [sccb_pkg::PDATA_W-1:0]   o_prdata,
    output logic                           o_pready,
    output logic [6:0]                     o_device_address
);
    import sccb_pkg::*;

    logic [6:0] r_dev_addr;
    logic       wr_en;
    t_reg_idx   idx;

    assign idx      = t_reg_idx'(i_paddr[PADDR_W-1]);
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
        end else if (wr_en && idx == REG_DEVICE_ADDRESS) begin
            r_dev_addr <= i_pwdata[6:0];
        end
    end

    always_comb begin
        o_prdata = '0;
        if (idx == REG_DEVICE_ADDRESS) begin
            o_prdata = {{(PDATA_W-7){1'b0}}, r_dev_addr};
        end
    end

    assign o_device_address = r_dev_addr;
endmodule

/* sv/sccb_register_master.sv */
`timescale 1ns / 1ps
// sccb / i2c master for 16-bit register write and read, one bus tick per transfer
// the result of a tick transfer is registered: it is on o_rsp in the cycle after it is accepted
// throughput: one tick per cycle while o_rsp is ready; the output register lets a new tick in while
//   the previous result is taken in the same cycle
// reset (synchronous, active low): sequencer idle, scl high, data line released,
//   read data and nack cleared, device address back to 92
// depends on sccb_pkg, sccb_if, sccb_apb_regs

module sccb_register_master (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    sccb_in_if.sink                        i_req,
    sccb_out_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sccb_pkg::PADDR_W-1:0]   paddr,
    input  logic [sccb_pkg::PDATA_W-1:0]   pwdata,
    output logic [sccb_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import sccb_pkg::*;

    // configuration
    logic [6:0] dev_addr;

    sccb_apb_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_psel           (psel),
        .i_penable        (penable),
        .i_pwrite         (pwrite),
        .i_paddr          (paddr),
        .i_pwdata         (pwdata),
        .o_prdata         (prdata),
        .o_pready         (pready),
        .o_device_address (dev_addr)
    );

    // sequencer state
    t_phase      r_phase,     n_phase;
    logic [3:0]  r_bit_idx,   n_bit_idx;
    logic [2:0]  r_byte_idx,  n_byte_idx;
    logic [7:0]  r_shift,     n_shift;
    logic [7:0]  r_held_reg,  n_held_reg;
    logic [15:0] r_held_val,  n_held_val;
    logic        r_held_kind, n_held_kind;
    // line levels: scl, output enable, data latch
    logic        r_scl,       n_scl;
    logic        r_oe,        n_oe;
    logic        r_sda,       n_sda;
    logic        r_nack_seen, n_nack_seen;
    logic [15:0] r_read_data, n_read_data;

    // result register
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;

    logic        in_fire;
    logic        busy;
    logic        done;
    t_phase      cur_phase;

    // byte sent at each position of the transaction
    function automatic logic [7:0] byte_for(
        input logic [2:0]  idx,
        input logic [6:0]  dev,
        input logic        kind,
        input logic [7:0]  regn,
        input logic [15:0] val
    );
        logic [7:0] b;
        b = 8'hFF;
        case (idx)
            3'd0:    b = {dev, 1'b0};
            3'd1:    b = regn;
            3'd2:    b = (kind == OP_READ) ? {dev, 1'b1} : val[15:8];
            3'd3:    b = val[7:0];
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

    // output register frees up when its content is taken this cycle
    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign in_fire     = i_req.valid && i_req.ready;

    always_comb begin
        n_phase     = r_phase;
        n_bit_idx   = r_bit_idx;
        n_byte_idx  = r_byte_idx;
        n_shift     = r_shift;
        n_held_reg  = r_held_reg;
        n_held_val  = r_held_val;
        n_held_kind = r_held_kind;
        n_scl       = r_scl;
        n_oe        = r_oe;
        n_sda       = r_sda;
        n_nack_seen = r_nack_seen;
        n_read_data = r_read_data;
        busy        = 1'b1;
        done        = 1'b0;
        cur_phase   = r_phase;

        // a request in idle makes this very tick the first start tick
        if (r_phase == PH_IDLE && i_req.payload.start_req) begin
            n_held_kind = i_req.payload.op;
            n_held_reg  = i_req.payload.reg_addr;
            n_held_val  = i_req.payload.write_data;
            n_nack_seen = 1'b0;
            n_byte_idx  = '0;
            n_bit_idx   = '0;
            cur_phase   = PH_ST1;
        end

        unique case (cur_phase)
            PH_ST1: begin
                {n_scl, n_oe, n_sda} = 3'b111;
                n_phase = PH_ST2;
            end
            PH_ST2: begin
                {n_scl, n_oe, n_sda} = 3'b110;
                n_shift   = byte_for(r_byte_idx, dev_addr, r_held_kind, r_held_reg,
                                     r_held_val);
                n_bit_idx = '0;
                n_phase   = PH_TXA;
            end
            PH_TXA: begin
                {n_scl, n_oe, n_sda} = {2'b01, r_sda};
                n_phase = PH_TXB;
            end
            PH_TXB: begin
                {n_scl, n_oe, n_sda} = {2'b01, r_shift[7]};
                n_phase = PH_TXC;
            end
            PH_TXC: begin
                {n_scl, n_oe, n_sda} = {2'b11, r_shift[7]};
                n_shift   = {r_shift[6:0], 1'b0};
                n_bit_idx = r_bit_idx + 4'd1;
                n_phase   = (n_bit_idx >= 4'd8) ? PH_AKA : PH_TXA;
            end
            PH_AKA: begin
                {n_scl, n_oe, n_sda} = {2'b00, r_sda};
                n_phase = PH_AKB;
            end
            PH_AKB: begin
                // slave acknowledge sampled while scl is high
                {n_scl, n_oe, n_sda} = {2'b10, r_sda};
                if (i_req.payload.sda_in) begin
                    n_nack_seen = 1'b1;
                end
                n_phase = PH_AKC;
            end
            PH_AKC: begin
                {n_scl, n_oe, n_sda} = {2'b00, r_sda};
                n_byte_idx = r_byte_idx + 3'd1;
                if (r_held_kind == OP_WRITE) begin
                    if (n_byte_idx < 3'd4) begin
                        n_shift   = byte_for(n_byte_idx, dev_addr, r_held_kind,
                                             r_held_reg, r_held_val);
                        n_bit_idx = '0;
                        n_phase   = PH_TXA;
                    end else begin
                        n_phase = PH_SP1;
                    end
                end else if (n_byte_idx == 3'd2) begin
                    // repeated start before the read address byte
                    n_phase = PH_ST1;
                end else if (n_byte_idx < 3'd2) begin
                    n_shift   = byte_for(n_byte_idx, dev_addr, r_held_kind,
                                         r_held_reg, r_held_val);
                    n_bit_idx = '0;
                    n_phase   = PH_TXA;
                end else begin
                    n_bit_idx = '0;
                    n_shift   = '0;
                    n_phase   = PH_RXA;
                end
            end
            PH_RXA: begin
                {n_scl, n_oe, n_sda} = {2'b00, r_sda};
                n_phase = PH_RXB;
            end
            PH_RXB: begin
                {n_scl, n_oe, n_sda} = {2'b10, r_sda};
                n_shift = {r_shift[6:0], i_req.payload.sda_in};
                n_phase = PH_RXC;
            end
            PH_RXC: begin
                {n_scl, n_oe, n_sda} = {2'b00, r_sda};
                n_bit_idx = r_bit_idx + 4'd1;
                n_phase   = (n_bit_idx >= 4'd8) ? PH_MAA : PH_RXA;
            end
            PH_MAA: begin
                {n_scl, n_oe, n_sda} = {2'b01, r_sda};
                n_phase = PH_MAB;
            end
            PH_MAB: begin
                // ack after the first received byte, nack after the second
                {n_scl, n_oe, n_sda} = {2'b01, (r_byte_idx != 3'd3)};
                n_phase = PH_MAC;
            end
            PH_MAC: begin
                {n_scl, n_oe, n_sda} = {2'b11, r_sda};
                n_held_val = {r_held_val[7:0], r_shift};
                n_byte_idx = r_byte_idx + 3'd1;
                if (n_byte_idx == 3'd4) begin
                    n_bit_idx = '0;
                    n_shift   = '0;
                    n_phase   = PH_RXA;
                end else begin
                    n_phase = PH_SP1;
                end
            end
            PH_SP1: begin
                {n_scl, n_oe, n_sda} = 3'b010;
                n_phase = PH_SP2;
            end
            PH_SP2: begin
                {n_scl, n_oe, n_sda} = 3'b110;
                n_phase = PH_SP3;
            end
            PH_SP3: begin
                {n_scl, n_oe, n_sda} = 3'b101;
                done = 1'b1;
                if (r_held_kind == OP_READ) begin
                    n_read_data = r_held_val;
                end
                n_phase = PH_IDLE;
            end
            default: begin
                // idle tick without a request: lines hold
                busy    = 1'b0;
                n_phase = PH_IDLE;
            end
        endcase

        n_out.scl       = n_scl;
        n_out.sda_oe    = n_oe;
        n_out.sda_out   = n_sda;
        n_out.busy_res  = busy;
        n_out.done_res  = done;
        n_out.read_data = n_read_data;
        n_out.nack      = n_nack_seen;
    end

    // sequencer state advances only on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_idx   <= '0;
            r_byte_idx  <= '0;
            r_shift     <= '0;
            r_held_reg  <= '0;
            r_held_val  <= '0;
            r_held_kind <= 1'b0;
            r_scl       <= 1'b1;
            r_oe        <= 1'b0;
            r_sda       <= 1'b1;
            r_nack_seen <= 1'b0;
            r_read_data <= '0;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_bit_idx   <= n_bit_idx;
            r_byte_idx  <= n_byte_idx;
            r_shift     <= n_shift;
            r_held_reg  <= n_held_reg;
            r_held_val  <= n_held_val;
            r_held_kind <= n_held_kind;
            r_scl       <= n_scl;
            r_oe        <= n_oe;
            r_sda       <= n_sda;
            r_nack_seen <= n_nack_seen;
            r_read_data <= n_read_data;
        end
    end

    // result register: valid is control, payload loads on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= in_fire || (r_out_valid && !o_rsp.ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    // a done pulse always falls on a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_out.done_res |-> n_out.busy_res)
        else $error("done without busy");

    // the stop tick returns the sequencer to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && n_out.done_res |=> r_phase == PH_IDLE)
        else $error("sequencer not idle after stop");

    // read data moves only on a done tick
    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !n_out.done_res |=> r_read_data == $past(r_read_data))
        else $error("read data changed outside a done tick");

    // a new transaction starts with the nack flag clear
    a_nack_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && r_phase == PH_IDLE && i_req.payload.start_req
        |=> !r_nack_seen && r_phase == PH_ST2)
        else $error("start did not clear nack");
endmodule
